[design/cvr_pkg.sv]
// Package for the axis rotation block: axis codes, pipeline control struct,
// CORDIC gain and arctangent table. No dependencies.
package cvr_pkg;

  localparam int unsigned COORD_WIDTH_DEF    = 32;
  localparam int unsigned ROTATION_STEPS_DEF = 16;
  localparam int unsigned GUARD_BITS         = 8;
  localparam int unsigned HEADROOM_BITS      = 4;
  localparam int unsigned ANGLE_BITS         = 16;
  localparam int unsigned ACC_WIDTH          = 34;
  localparam logic [31:0] GAIN_Q32           = 32'h9B74EDA8;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } cvr_axis_t;

  typedef struct packed {
    logic      valid;
    cvr_axis_t axis;
  } cvr_ctl_t;

  // atan(2^-i) in units of 2^-32 turn, truncated
  function automatic logic [31:0] atan_q32(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051D;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2E;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      24:      v = 32'h00000028;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      28:      v = 32'h00000002;
      29:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[design/cvr_point_if.sv]
// Input channel carrying one point, its angle and axis code.
// Depends on nothing; width set by COORD_WIDTH.
interface cvr_point_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  logic signed [COORD_WIDTH-1:0] pz;
  logic [15:0]                   angle_turns;
  logic [1:0]                    axis;

  modport source (output valid, px, py, pz, angle_turns, axis, input ready);
  modport sink   (input valid, px, py, pz, angle_turns, axis, output ready);
endinterface

[design/cvr_result_if.sv]
// Output channel carrying one rotated point.
// Depends on nothing; width set by COORD_WIDTH.
interface cvr_result_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rx;
  logic signed [COORD_WIDTH-1:0] ry;
  logic signed [COORD_WIDTH-1:0] rz;

  modport source (output valid, rx, ry, rz, input ready);
  modport sink   (input valid, rx, ry, rz, output ready);
endinterface

[design/cvr_pre.sv]
// Entry stage: picks the plane pair, folds the angle into one half turn,
// scales the pair by the guard bits. Depends on cvr_pkg and cvr_point_if.
module cvr_pre
  import cvr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  cvr_point_if.sink                                      points,
  input  logic                                           en_next,
  output logic                                           en,
  output cvr_ctl_t                                       ctl,
  output logic signed [COORD_WIDTH-1:0]                  ox,
  output logic signed [COORD_WIDTH-1:0]                  oy,
  output logic signed [COORD_WIDTH-1:0]                  oz,
  output logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] u,
  output logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] w,
  output logic signed [ACC_WIDTH-1:0]                    zacc
);

  localparam int unsigned IW = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;

  logic signed [COORD_WIDTH-1:0] a_sel;
  logic signed [COORD_WIDTH-1:0] b_sel;
  logic signed [IW-1:0]          a_ext;
  logic signed [IW-1:0]          b_ext;
  logic signed [16:0]            s_raw;
  logic signed [16:0]            s_fold;
  logic                          flip;
  logic signed [IW-1:0]          u_next;
  logic signed [IW-1:0]          w_next;
  logic signed [ACC_WIDTH-1:0]   z_next;
  cvr_axis_t                     axis_in;

  assign en           = !ctl.valid || en_next;
  assign points.ready = en;
  assign axis_in      = cvr_axis_t'(points.axis);

  always_comb begin
    unique case (axis_in)
      AXIS_X: begin
        a_sel = points.py;
        b_sel = points.pz;
      end
      AXIS_Y: begin
        a_sel = points.pz;
        b_sel = points.px;
      end
      AXIS_Z: begin
        a_sel = points.px;
        b_sel = points.py;
      end
      default: begin
        a_sel = points.px;
        b_sel = points.py;
      end
    endcase
  end

  always_comb begin
    s_raw = $signed({points.angle_turns[ANGLE_BITS-1], points.angle_turns});
    flip  = 1'b0;
    if (s_raw > 17'sd16384) begin
      s_fold = s_raw - 17'sd32768;
      flip   = 1'b1;
    end else if (s_raw < -17'sd16384) begin
      s_fold = s_raw + 17'sd32768;
      flip   = 1'b1;
    end else begin
      s_fold = s_raw;
    end
    z_next = {{(ACC_WIDTH-33){s_fold[16]}}, s_fold, 16'b0};
  end

  always_comb begin
    a_ext = {{(IW-COORD_WIDTH){a_sel[COORD_WIDTH-1]}}, a_sel};
    b_ext = {{(IW-COORD_WIDTH){b_sel[COORD_WIDTH-1]}}, b_sel};
    if (flip) begin
      a_ext = -a_ext;
      b_ext = -b_ext;
    end
    u_next = {a_ext[IW-GUARD_BITS-1:0], {GUARD_BITS{1'b0}}};
    w_next = {b_ext[IW-GUARD_BITS-1:0], {GUARD_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= points.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.axis <= axis_in;
      ox       <= points.px;
      oy       <= points.py;
      oz       <= points.pz;
      u        <= u_next;
      w        <= w_next;
      zacc     <= z_next;
    end
  end

endmodule

[design/cvr_cordic_step.sv]
// One registered CORDIC micro-rotation with a fixed shift of STEP.
// Depends on cvr_pkg.
module cvr_cordic_step
  import cvr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned STEP        = 0
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           en_next,
  output logic                                           en,
  input  cvr_ctl_t                                       ctl_in,
  input  logic signed [COORD_WIDTH-1:0]                  ox_in,
  input  logic signed [COORD_WIDTH-1:0]                  oy_in,
  input  logic signed [COORD_WIDTH-1:0]                  oz_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] u_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] w_in,
  input  logic signed [ACC_WIDTH-1:0]                    z_in,
  output cvr_ctl_t                                       ctl,
  output logic signed [COORD_WIDTH-1:0]                  ox,
  output logic signed [COORD_WIDTH-1:0]                  oy,
  output logic signed [COORD_WIDTH-1:0]                  oz,
  output logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] u,
  output logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] w,
  output logic signed [ACC_WIDTH-1:0]                    zacc
);

  localparam int unsigned IW        = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam logic [31:0] ATAN_STEP = atan_q32(STEP);

  logic signed [ACC_WIDTH-1:0] atan_ext;
  logic signed [IW-1:0]        du;
  logic signed [IW-1:0]        dw;
  logic signed [IW-1:0]        u_next;
  logic signed [IW-1:0]        w_next;
  logic signed [ACC_WIDTH-1:0] z_next;

  assign en       = !ctl.valid || en_next;
  assign atan_ext = $signed({{(ACC_WIDTH-32){1'b0}}, ATAN_STEP});
  assign du       = w_in >>> STEP;
  assign dw       = u_in >>> STEP;

  always_comb begin
    if (!z_in[ACC_WIDTH-1]) begin
      u_next = u_in - du;
      w_next = w_in + dw;
      z_next = z_in - atan_ext;
    end else begin
      u_next = u_in + du;
      w_next = w_in - dw;
      z_next = z_in + atan_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.axis <= ctl_in.axis;
      ox       <= ox_in;
      oy       <= oy_in;
      oz       <= oz_in;
      u        <= u_next;
      w        <= w_next;
      zacc     <= z_next;
    end
  end

endmodule

[design/cvr_scale.sv]
// Gain correction and output: magnitude, split 32-bit gain products,
// rounding, saturation and axis reassembly. Depends on cvr_pkg, cvr_result_if.
module cvr_scale
  import cvr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  output logic                                           en,
  input  cvr_ctl_t                                       ctl_in,
  input  logic signed [COORD_WIDTH-1:0]                  ox_in,
  input  logic signed [COORD_WIDTH-1:0]                  oy_in,
  input  logic signed [COORD_WIDTH-1:0]                  oz_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] u_in,
  input  logic signed [COORD_WIDTH+GUARD_BITS+HEADROOM_BITS-1:0] w_in,
  cvr_result_if.source                                   rotated
);

  localparam int unsigned IW  = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam int unsigned ML  = (IW + 1) / 2;
  localparam int unsigned MH  = IW - ML;
  localparam int unsigned SW  = IW + 33;
  localparam int unsigned SH  = 32 + GUARD_BITS;
  localparam int unsigned RW  = SW - SH;
  localparam logic [SW-1:0] RND = SW'(1) << (31 + GUARD_BITS);
  localparam logic [RW-1:0] LIM = RW'(1) << (COORD_WIDTH - 1);

  function automatic logic [COORD_WIDTH-1:0] saturate(input logic neg,
                                                      input logic [RW-1:0] r);
    logic [COORD_WIDTH-1:0] rl;
    logic [COORD_WIDTH-1:0] v;
    rl = r[COORD_WIDTH-1:0];
    if (r >= LIM) begin
      v = neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      v = neg ? (~rl + 1'b1) : rl;
    end
    return v;
  endfunction

  // stage A: magnitude and sign
  cvr_ctl_t                      ctl_a;
  logic signed [COORD_WIDTH-1:0] ox_a, oy_a, oz_a;
  logic [IW-1:0]                 mag_a [2];
  logic                          neg_a [2];
  logic signed [IW-1:0]          lane_in [2];

  // stage B: partial products
  cvr_ctl_t                      ctl_b;
  logic signed [COORD_WIDTH-1:0] ox_b, oy_b, oz_b;
  logic [ML+31:0]                plo_b [2];
  logic [MH+31:0]                phi_b [2];
  logic                          neg_b [2];

  // stage C: rounded, saturated result
  logic [SW-1:0]                 sum_c [2];
  logic [COORD_WIDTH-1:0]        res_c [2];
  logic [COORD_WIDTH-1:0]        rx_next, ry_next, rz_next;
  logic                          en_a, en_b, en_c;

  assign en_c = !rotated.valid || rotated.ready;
  assign en_b = !ctl_b.valid || en_c;
  assign en_a = !ctl_a.valid || en_b;
  assign en   = en_a;

  assign lane_in[0] = u_in;
  assign lane_in[1] = w_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid   <= 1'b0;
      ctl_b.valid   <= 1'b0;
      rotated.valid <= 1'b0;
    end else begin
      if (en_a) ctl_a.valid <= ctl_in.valid;
      if (en_b) ctl_b.valid <= ctl_a.valid;
      if (en_c) rotated.valid <= ctl_b.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ctl_a.axis <= ctl_in.axis;
      ox_a       <= ox_in;
      oy_a       <= oy_in;
      oz_a       <= oz_in;
      for (int k = 0; k < 2; k++) begin
        neg_a[k] <= lane_in[k][IW-1];
        mag_a[k] <= lane_in[k][IW-1] ? (~lane_in[k] + 1'b1) : lane_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      ctl_b.axis <= ctl_a.axis;
      ox_b       <= ox_a;
      oy_b       <= oy_a;
      oz_b       <= oz_a;
      for (int k = 0; k < 2; k++) begin
        neg_b[k] <= neg_a[k];
        plo_b[k] <= (ML+32)'(mag_a[k][ML-1:0]) * (ML+32)'(GAIN_Q32);
        phi_b[k] <= (MH+32)'(mag_a[k][IW-1:ML]) * (MH+32)'(GAIN_Q32);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sum_c[k] = (SW'(phi_b[k]) << ML) + SW'(plo_b[k]) + RND;
      res_c[k] = saturate(neg_b[k], sum_c[k][SW-1:SH]);
    end
  end

  always_comb begin
    rx_next = ox_b;
    ry_next = oy_b;
    rz_next = oz_b;
    unique case (ctl_b.axis)
      AXIS_X: begin
        ry_next = res_c[0];
        rz_next = res_c[1];
      end
      AXIS_Y: begin
        rz_next = res_c[0];
        rx_next = res_c[1];
      end
      AXIS_Z: begin
        rx_next = res_c[0];
        ry_next = res_c[1];
      end
      default: begin
        rx_next = ox_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      rotated.rx <= rx_next;
      rotated.ry <= ry_next;
      rotated.rz <= rz_next;
    end
  end

endmodule

[design/vector_rotate_about_axis.sv]
// Rotates a Q.16 point about the x, y or z axis by a 16-bit binary angle,
// using an entry stage, ROTATION_STEPS CORDIC stages and three gain stages.
// Depends on cvr_pkg, cvr_point_if, cvr_result_if, cvr_pre, cvr_cordic_step,
// cvr_scale.
//
// One point is taken on every clock while the output side keeps up; each
// point passes through one register stage per step of the CORDIC chain
// plus entry, magnitude, gain product and round/saturate stages. Every
// stage holds its own valid bit and advances whenever the stage after it
// can take data, so a bubble anywhere in the chain lets a new point enter
// while a finished result waits. The rotated pair is rounded to nearest,
// ties away from zero, and saturated; the coordinate on the axis passes
// unchanged, and axis code three returns the point untouched.
module vector_rotate_about_axis
  import cvr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int unsigned ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cvr_point_if.sink    points,
  cvr_result_if.source rotated
);

  localparam int unsigned IW    = COORD_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam int unsigned DEPTH = ROTATION_STEPS + 4;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  cvr_ctl_t                      ctl_s  [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] ox_s   [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] oy_s   [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] oz_s   [ROTATION_STEPS+1];
  logic signed [IW-1:0]          u_s    [ROTATION_STEPS+1];
  logic signed [IW-1:0]          w_s    [ROTATION_STEPS+1];
  logic signed [ACC_WIDTH-1:0]   z_s    [ROTATION_STEPS+1];
  logic                          en_s   [ROTATION_STEPS+2];
  logic [CW-1:0]                 inflight;

  cvr_pre #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_pre (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .en_next (en_s[1]),
    .en      (en_s[0]),
    .ctl     (ctl_s[0]),
    .ox      (ox_s[0]),
    .oy      (oy_s[0]),
    .oz      (oz_s[0]),
    .u       (u_s[0]),
    .w       (w_s[0]),
    .zacc    (z_s[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_step
    cvr_cordic_step #(
      .COORD_WIDTH(COORD_WIDTH),
      .STEP       (i)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en_next (en_s[i+2]),
      .en      (en_s[i+1]),
      .ctl_in  (ctl_s[i]),
      .ox_in   (ox_s[i]),
      .oy_in   (oy_s[i]),
      .oz_in   (oz_s[i]),
      .u_in    (u_s[i]),
      .w_in    (w_s[i]),
      .z_in    (z_s[i]),
      .ctl     (ctl_s[i+1]),
      .ox      (ox_s[i+1]),
      .oy      (oy_s[i+1]),
      .oz      (oz_s[i+1]),
      .u       (u_s[i+1]),
      .w       (w_s[i+1]),
      .zacc    (z_s[i+1])
    );
  end

  cvr_scale #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en_s[ROTATION_STEPS+1]),
    .ctl_in  (ctl_s[ROTATION_STEPS]),
    .ox_in   (ox_s[ROTATION_STEPS]),
    .oy_in   (oy_s[ROTATION_STEPS]),
    .oz_in   (oz_s[ROTATION_STEPS]),
    .u_in    (u_s[ROTATION_STEPS]),
    .w_in    (w_s[ROTATION_STEPS]),
    .rotated (rotated)
  );

  // track transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(points.valid && points.ready)
                           - CW'(rotated.valid && rotated.ready);
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !points.ready |-> rotated.valid && !rotated.ready)
    else $error("input stalled while output side was free");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(DEPTH))
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom_output: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !rotated.valid)
    else $error("output valid with nothing in flight");

endmodule
